/* rtl/pfx_pkg.sv */
// Shared types, codes and constants for the postfix expression evaluator.
`timescale 1ns / 1ps
package pfx_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int SYMBOL_W   = 8;
  localparam int LIMIT_W    = 7;
  localparam int OUT_VALUE_W = 16;
  localparam int STATUS_W   = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [SYMBOL_W-1:0] CH_ZERO = 8'h30;
  localparam logic [SYMBOL_W-1:0] CH_NINE = 8'h39;
  localparam logic [SYMBOL_W-1:0] CH_ADD  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CH_SUB  = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CH_MUL  = 8'h2A;
  localparam logic [SYMBOL_W-1:0] CH_DIV  = 8'h2F;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic exec;
    logic div_start;
    logic div_take;
    logic push;
    logic emit;
  } pfx_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic is_last;
    logic b_zero;
    logic div_done;
    logic out_busy;
  } pfx_stat_t;

endpackage

/* rtl/pfx_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module pfx_div #(
  parameter int VALUE_WIDTH = pfx_pkg::DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int VW = VALUE_WIDTH;
  localparam int CNT_W = $clog2(VW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [VW-1:0]     rem;
  logic [VW-1:0]     quo;
  logic [VW-1:0]     mag_b;
  logic              neg;
  logic [VW:0]       shifted;
  logic [VW:0]       diff;

  assign shifted  = {rem, quo[VW-1]};
  assign diff     = shifted - {1'b0, mag_b};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(VW);
        rem   <= '0;
        quo   <= dividend[VW-1] ? (~dividend + 1'b1) : dividend;
        mag_b <= divisor[VW-1] ? (~divisor + 1'b1) : divisor;
        neg   <= dividend[VW-1] ^ divisor[VW-1];
      end else if (busy) begin
        if (!diff[VW]) begin
          rem <= diff[VW-1:0];
        end else begin
          rem <= shifted[VW-1:0];
        end
        quo <= {quo[VW-2:0], ~diff[VW]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/pfx_datapath.sv */
// Operand stack, arithmetic, error tracking and result register.
`timescale 1ns / 1ps
module pfx_datapath #(
  parameter int STACK_DEPTH = pfx_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = pfx_pkg::DEF_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pfx_pkg::SYMBOL_W-1:0]     symbol_in,
  input  logic                             last_in,
  input  logic                             limit_wr_en,
  input  logic [pfx_pkg::LIMIT_W-1:0]      limit_wr_data,
  input  pfx_pkg::pfx_cmd_t                cmd,
  input  logic                             out_ready,
  output pfx_pkg::pfx_stat_t               st,
  output logic                             out_valid,
  output logic [pfx_pkg::OUT_VALUE_W-1:0]  out_value,
  output logic [pfx_pkg::STATUS_W-1:0]     out_status
);
  import pfx_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int LW   = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [VW-1:0]       mem [STACK_DEPTH];
  logic [VW-1:0]       rdata;
  logic [AW-1:0]       raddr;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_m1;
  status_t             err;
  logic [LIMIT_W-1:0]  stack_limit;
  logic [SYMBOL_W-1:0] sym;
  logic                lst;
  logic                rd_zero;
  logic [VW-1:0]       b_op;
  logic [VW-1:0]       popped;
  logic [VW-1:0]       result;
  logic [LW-1:0]       lim_ext;
  logic [LW-1:0]       eff_lim;
  logic                full;
  logic                div_done;
  logic [VW-1:0]       div_q;
  logic [OUT_VALUE_W-1:0] top_val;

  pfx_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (popped),
    .divisor  (b_op),
    .done     (div_done),
    .quotient (div_q)
  );

  assign count_m1 = count - 1'b1;
  assign raddr    = count_m1[AW-1:0];
  assign popped   = rd_zero ? '0 : rdata;
  assign lim_ext  = LW'(stack_limit);

  always_comb begin
    if (lim_ext == '0) begin
      eff_lim = LW'(1);
    end else if (lim_ext > LW'(STACK_DEPTH)) begin
      eff_lim = LW'(STACK_DEPTH);
    end else begin
      eff_lim = lim_ext;
    end
  end

  assign full    = LW'(count) >= eff_lim;
  assign top_val = OUT_VALUE_W'((count != '0) ? rdata : {VW{1'b0}});

  assign st.is_digit = (sym >= CH_ZERO) && (sym <= CH_NINE);
  assign st.is_op    = (sym == CH_ADD) || (sym == CH_SUB) ||
                       (sym == CH_MUL) || (sym == CH_DIV);
  assign st.is_div   = (sym == CH_DIV);
  assign st.is_last  = lst;
  assign st.b_zero   = (b_op == '0);
  assign st.div_done = div_done;
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[count[AW-1:0]] <= result;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym <= symbol_in;
      lst <= last_in;
    end
    if (cmd.pop) begin
      rd_zero <= (count == '0);
      b_op    <= popped;
    end
    if (cmd.load) begin
      result <= VW'(symbol_in[3:0]);
    end else if (cmd.exec) begin
      unique case (sym)
        CH_ADD:  result <= popped + b_op;
        CH_SUB:  result <= popped - b_op;
        CH_MUL:  result <= popped * b_op;
        default: result <= '0;
      endcase
    end else if (cmd.div_take) begin
      result <= div_q;
    end
    if (cmd.emit) begin
      out_value <= top_val;
      if (err != ST_OK) begin
        out_status <= err;
      end else if (count == '0) begin
        out_status <= ST_EMPTY;
      end else begin
        out_status <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      err         <= ST_OK;
      stack_limit <= LIMIT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (limit_wr_en) begin
        stack_limit <= limit_wr_data;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      priority if (cmd.emit) begin
        count <= '0;
        err   <= ST_OK;
      end else if (cmd.pop) begin
        if (count == '0) begin
          if (err == ST_OK) err <= ST_UNDERFLOW;
        end else begin
          count <= count_m1;
        end
      end else if (cmd.push) begin
        if (full) begin
          if (err == ST_OK) err <= ST_OVERFLOW;
        end else begin
          count <= count + 1'b1;
        end
      end else if (cmd.exec && st.is_div && st.b_zero) begin
        if (err == ST_OK) err <= ST_DIVZERO;
      end
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.push && full |=> $stable(count))
    else $error("push on full stack changed count");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (count == '0) && (err == ST_OK))
    else $error("stack or error not cleared after result");

  a_empty_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_EMPTY) |-> (out_value == '0))
    else $error("empty status with nonzero value");

endmodule

/* rtl/pfx_ctrl.sv */
// Sequencing state machine for the postfix expression evaluator.
`timescale 1ns / 1ps
module pfx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pfx_pkg::pfx_stat_t  st,
  output logic                ready,
  output pfx_pkg::pfx_cmd_t   cmd
);
  import pfx_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_B,
    S_POP_A,
    S_EXEC,
    S_DIV,
    S_PUSH,
    S_FIN_RD,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (st.is_digit) begin
          state_next = S_PUSH;
        end else if (st.is_op) begin
          state_next = S_POP_B;
        end else if (st.is_last) begin
          state_next = S_FIN_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP_B: begin
        cmd.pop    = 1'b1;
        state_next = S_POP_A;
      end
      S_POP_A: begin
        cmd.pop    = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.is_div && !st.b_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = st.is_last ? S_FIN_RD : S_IDLE;
      end
      S_FIN_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_single_pop_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_B) |=> (state == S_POP_A))
    else $error("operand pops out of order");

  a_div_start_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> cmd.exec && st.is_div && !st.b_zero)
    else $error("divider started outside divide");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> ready && in_valid)
    else $error("symbol loaded while busy");

endmodule

/* rtl/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator.
`timescale 1ns / 1ps
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata/s_tlast) carries one ASCII symbol
//   per transfer; s_tlast marks the final symbol of an expression. Digits push,
//   + - * / pop two operands and push the result, other symbols are skipped.
//   Master channel carries one result per expression: m_tdata holds the value
//   left on top of the stack and a status code (ok, overflow, underflow,
//   divide by zero, empty at end).
//   stack_limit_wr_en/stack_limit_wr_data write the usable stack depth; write
//   it only while the block is idle.
//   Steps per symbol: an ignored symbol is loaded and decoded, a digit is also
//   pushed, + - * also pop two operands and execute, and divide also waits
//   on the one-bit-per-cycle divider unless the divisor is zero. A final symbol
//   adds the top-of-stack memory read and the result register load.
//   One symbol is in work at a time; the next is taken while a result waits.
//   Reset empties the stack, clears the error and sets stack_limit to 64.
//   If the receiver stalls, the result is held in the output register and
//   the block stops before loading the next result until it is taken.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfx_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = pfx_pkg::DEF_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             stack_limit_wr_en,
  input  logic [pfx_pkg::LIMIT_W-1:0]      stack_limit_wr_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pfx_pkg::SYMBOL_W-1:0]     s_tdata,   // [7:0] symbol
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pfx_pkg::OUT_DATA_W-1:0]   m_tdata    // [15:0] value, [18:16] status
);
  import pfx_pkg::*;

  pfx_cmd_t                cmd;
  pfx_stat_t               st;
  logic [OUT_VALUE_W-1:0]  out_value;
  logic [STATUS_W-1:0]     out_status;

  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .st       (st),
    .ready    (s_tready),
    .cmd      (cmd)
  );

  pfx_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .symbol_in     (s_tdata),
    .last_in       (s_tlast),
    .limit_wr_en   (stack_limit_wr_en),
    .limit_wr_data (stack_limit_wr_data),
    .cmd           (cmd),
    .out_ready     (m_tready),
    .st            (st),
    .out_valid     (m_tvalid),
    .out_value     (out_value),
    .out_status    (out_status)
  );

  assign m_tdata = {{(OUT_DATA_W - OUT_VALUE_W - STATUS_W){1'b0}}, out_status, out_value};

endmodule
